// File: hdl/llae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package llae_pkg;

  localparam int BOARD_WIDTH_DEF  = 128;
  localparam int BOARD_HEIGHT_DEF = 128;
  localparam int QUEUE_DEPTH      = 4;

  localparam int COORD_IN_W   = 7;
  localparam int FUNC_W       = 2;
  localparam int MASK_W       = 9;
  localparam int COUNT_W      = 4;
  localparam int HEAT_W       = 24;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 9;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 40;

  localparam logic [FUNC_W-1:0] FUNC_SEED   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EVOLVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SWAP   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_BORN_MASK    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SURVIVE_MASK = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SHOW_LIFE    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SHOW_HEAT    = 2'd3;

  localparam logic [MASK_W-1:0] BORN_MASK_RST    = 9'd456;
  localparam logic [MASK_W-1:0] SURVIVE_MASK_RST = 9'd472;

  localparam logic [HEAT_W-1:0] HEAT_BLUE_TOP  = 24'h0000FF;
  localparam logic [HEAT_W-1:0] HEAT_GREEN_TOP = 24'h00FFFF;
  localparam logic [HEAT_W-1:0] HEAT_TOP       = 24'hFFFF00;
  localparam logic [HEAT_W-1:0] HEAT_STEP_RED  = 24'h010000;
  localparam logic [HEAT_W-1:0] HEAT_STEP_GRN  = 24'h000100;
  localparam logic [HEAT_W-1:0] HEAT_STEP_ONE  = 24'h000001;
  localparam logic [HEAT_W-1:0] COLOR_RED      = 24'hFF0000;

  typedef struct packed {
    logic [MASK_W-1:0] born_mask;
    logic [MASK_W-1:0] survive_mask;
    logic              live_red_en;
    logic              heat_view_en;
  } llae_cfg_t;

  function automatic logic [HEAT_W-1:0] heat_next(input logic [HEAT_W-1:0] h);
    logic [HEAT_W-1:0] res;
    if (h < HEAT_BLUE_TOP) begin
      res = h + HEAT_STEP_ONE;
    end else if (h < HEAT_GREEN_TOP) begin
      res = h + HEAT_STEP_GRN;
    end else if (h < HEAT_TOP) begin
      res = h + HEAT_STEP_RED - HEAT_STEP_ONE;
    end else begin
      res = h;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: hdl/life_like_automaton_engine_top.sv
// Evolve words: the nine board reads go over the two read ports of the bank memory in
// S_RD0..S_RD4; the next word is taken from the queue only once back in S_IDLE.
// Seed and swap words retire in S_IDLE in the back end and give no output.
// Reset (rst_n low, synchronous) restores the rule registers and bank selection, then
// a heat clearing pass over all BOARD_WIDTH * BOARD_HEIGHT cells (16384 by default)
// runs with in_tready held low.
`timescale 1ns / 1ps
`default_nettype none
module life_like_automaton_engine_top
  import llae_pkg::*;
#(
  parameter int BOARD_WIDTH  = BOARD_WIDTH_DEF,
  parameter int BOARD_HEIGHT = BOARD_HEIGHT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // col [6:0], row [13:7], seed_value [14], zero [15]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // func [1:0]
  input  wire logic [FUNC_W-1:0]      in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // out_col [6:0], out_row [13:7], next_alive [14], pixel_color [38:15], zero [39]
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int COL_W   = $clog2(BOARD_WIDTH);
  localparam int ROW_W   = $clog2(BOARD_HEIGHT);
  localparam int ADDR_W  = $clog2(BOARD_WIDTH * BOARD_HEIGHT);
  localparam int ENTRY_W = FUNC_W + 1 + 3 * COL_W + ROW_W + 3 * ADDR_W;

  llae_cfg_t        cfg_r, cfg_nxt;
  logic             clearing;
  logic             q_push, q_ready, q_pop, q_valid;
  logic [ENTRY_W-1:0] q_in, q_out;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_BORN_MASK:    cfg_nxt.born_mask    = cfg_wdata;
        REG_SURVIVE_MASK: cfg_nxt.survive_mask = cfg_wdata;
        REG_SHOW_LIFE:    cfg_nxt.live_red_en  = cfg_wdata[0];
        REG_SHOW_HEAT:    cfg_nxt.heat_view_en = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.born_mask    <= BORN_MASK_RST;
      cfg_r.survive_mask <= SURVIVE_MASK_RST;
      cfg_r.live_red_en  <= 1'b1;
      cfg_r.heat_view_en <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  llae_front #(
    .BOARD_WIDTH  (BOARD_WIDTH),
    .BOARD_HEIGHT (BOARD_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .clearing  (clearing),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  llae_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_data   (q_out),
    .pop_valid  (q_valid)
  );

  llae_back #(
    .BOARD_WIDTH  (BOARD_WIDTH),
    .BOARD_HEIGHT (BOARD_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// File: hdl/llae_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module llae_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr_a,
  output logic      [WIDTH-1:0] rd_data_a,
  input  wire logic [AW-1:0]    rd_addr_b,
  output logic      [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_a <= mem_r[rd_addr_a];
    rd_data_b <= mem_r[rd_addr_b];
  end

endmodule
`default_nettype wire

// File: hdl/llae_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module llae_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  push_ready,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  pop_valid
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: hdl/llae_front.sv
`timescale 1ns / 1ps
`default_nettype none
module llae_front
  import llae_pkg::*;
#(
  parameter int BOARD_WIDTH  = BOARD_WIDTH_DEF,
  parameter int BOARD_HEIGHT = BOARD_HEIGHT_DEF,
  localparam int COL_W   = $clog2(BOARD_WIDTH),
  localparam int ROW_W   = $clog2(BOARD_HEIGHT),
  localparam int ADDR_W  = $clog2(BOARD_WIDTH * BOARD_HEIGHT),
  localparam int ENTRY_W = FUNC_W + 1 + 3 * COL_W + ROW_W + 3 * ADDR_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic [FUNC_W-1:0]     in_tuser,
  input  wire logic                  clearing,
  input  wire logic                  q_ready,
  output logic                       q_push,
  output logic      [ENTRY_W-1:0]    q_data
);

  localparam int IN_SPAN = 1 << COORD_IN_W;

  logic [COL_W-1:0]  col_tab [IN_SPAN];
  logic [ROW_W-1:0]  row_tab [IN_SPAN];

  logic              st_valid_r, st_valid_nxt;
  logic [FUNC_W-1:0] st_kind_r;
  logic [COL_W-1:0]  st_c_r;
  logic [ROW_W-1:0]  st_r_r;
  logic              st_seed_r;
  logic              in_acc;

  logic [COL_W-1:0]  cl, cr;
  logic [ROW_W-1:0]  ru, rd;
  logic [ADDR_W-1:0] bu, bh, bd;

  for (genvar gi = 0; gi < IN_SPAN; gi++) begin : g_wrap
    assign col_tab[gi] = COL_W'(gi % BOARD_WIDTH);
    assign row_tab[gi] = ROW_W'(gi % BOARD_HEIGHT);
  end

  assign in_tready = !clearing && (!st_valid_r || q_ready);
  assign in_acc    = in_tvalid && in_tready;
  assign q_push    = st_valid_r && q_ready;

  always_comb begin
    if (in_acc) begin
      st_valid_nxt = (in_tuser != FUNC_NONE);
    end else if (q_push) begin
      st_valid_nxt = 1'b0;
    end else begin
      st_valid_nxt = st_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      st_kind_r <= in_tuser;
      st_c_r    <= col_tab[in_tdata[COORD_IN_W-1:0]];
      st_r_r    <= row_tab[in_tdata[2*COORD_IN_W-1:COORD_IN_W]];
      st_seed_r <= in_tdata[2*COORD_IN_W];
    end
  end

  always_comb begin
    cl = (st_c_r == '0) ? COL_W'(BOARD_WIDTH - 1) : st_c_r - COL_W'(1);
    cr = (st_c_r == COL_W'(BOARD_WIDTH - 1)) ? '0 : st_c_r + COL_W'(1);
    ru = (st_r_r == '0) ? ROW_W'(BOARD_HEIGHT - 1) : st_r_r - ROW_W'(1);
    rd = (st_r_r == ROW_W'(BOARD_HEIGHT - 1)) ? '0 : st_r_r + ROW_W'(1);
    bu = ADDR_W'(ru) * ADDR_W'(BOARD_WIDTH);
    bh = ADDR_W'(st_r_r) * ADDR_W'(BOARD_WIDTH);
    bd = ADDR_W'(rd) * ADDR_W'(BOARD_WIDTH);
  end

  assign q_data = {st_kind_r, st_seed_r, st_c_r, cl, cr, st_r_r, bu, bh, bd};

endmodule
`default_nettype wire

// File: hdl/llae_back.sv
`timescale 1ns / 1ps
`default_nettype none
module llae_back
  import llae_pkg::*;
#(
  parameter int BOARD_WIDTH  = BOARD_WIDTH_DEF,
  parameter int BOARD_HEIGHT = BOARD_HEIGHT_DEF,
  localparam int CELLS   = BOARD_WIDTH * BOARD_HEIGHT,
  localparam int COL_W   = $clog2(BOARD_WIDTH),
  localparam int ROW_W   = $clog2(BOARD_HEIGHT),
  localparam int ADDR_W  = $clog2(CELLS),
  localparam int ENTRY_W = FUNC_W + 1 + 3 * COL_W + ROW_W + 3 * ADDR_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire llae_cfg_t              cfg,
  input  wire logic                   q_valid,
  input  wire logic [ENTRY_W-1:0]     q_data,
  output logic                        q_pop,
  output logic                        clearing,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD0   = 4'd2;
  localparam logic [3:0] S_RD1   = 4'd3;
  localparam logic [3:0] S_RD2   = 4'd4;
  localparam logic [3:0] S_RD3   = 4'd5;
  localparam logic [3:0] S_RD4   = 4'd6;
  localparam logic [3:0] S_SUM   = 4'd7;
  localparam logic [3:0] S_EVAL  = 4'd8;

  logic [FUNC_W-1:0] e_kind;
  logic              e_seed;
  logic [COL_W-1:0]  e_c, e_cl, e_cr;
  logic [ROW_W-1:0]  e_r;
  logic [ADDR_W-1:0] e_bu, e_bh, e_bd;

  logic [3:0]        state_r, state_nxt;
  logic              sel_r, sel_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic              load_item;
  logic [COL_W-1:0]  c_r, cl_r, cr_r;
  logic [ROW_W-1:0]  r_r;
  logic [ADDR_W-1:0] bu_r, bh_r, bd_r;
  logic              alive_r, alive_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [HEAT_W-1:0] heat_r, heat_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  logic [COORD_IN_W-1:0] out_col_r, out_row_r;
  logic              out_alive_r;
  logic [HEAT_W-1:0] out_color_r;

  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b, here_addr;
  logic              b0_a, b0_b, b1_a, b1_b, rd_a, rd_b;
  logic              bw_en0, bw_en1, bw_data;
  logic [ADDR_W-1:0] bw_addr;
  logic              hw_en;
  logic [ADDR_W-1:0] hw_addr;
  logic [HEAT_W-1:0] hw_data, heat_rd;
  logic              next_alive;
  logic [HEAT_W-1:0] color;

  assign {e_kind, e_seed, e_c, e_cl, e_cr, e_r, e_bu, e_bh, e_bd} = q_data;

  assign here_addr = bh_r + ADDR_W'(c_r);
  assign rd_a      = sel_r ? b1_a : b0_a;
  assign rd_b      = sel_r ? b1_b : b0_b;
  assign clearing  = (state_r == S_CLEAR);

  always_comb begin
    unique case (state_r)
      S_RD0: begin
        rd_addr_a = here_addr;
        rd_addr_b = bu_r + ADDR_W'(cl_r);
      end
      S_RD1: begin
        rd_addr_a = bu_r + ADDR_W'(c_r);
        rd_addr_b = bu_r + ADDR_W'(cr_r);
      end
      S_RD2: begin
        rd_addr_a = bh_r + ADDR_W'(cl_r);
        rd_addr_b = bh_r + ADDR_W'(cr_r);
      end
      S_RD3: begin
        rd_addr_a = bd_r + ADDR_W'(cl_r);
        rd_addr_b = bd_r + ADDR_W'(c_r);
      end
      S_RD4: begin
        rd_addr_a = bd_r + ADDR_W'(cr_r);
        rd_addr_b = bd_r + ADDR_W'(cr_r);
      end
      default: begin
        rd_addr_a = here_addr;
        rd_addr_b = here_addr;
      end
    endcase
  end

  assign next_alive = alive_r ? cfg.survive_mask[cnt_r] : cfg.born_mask[cnt_r];

  always_comb begin
    if (next_alive && cfg.live_red_en) begin
      color = COLOR_RED;
    end else if (cfg.heat_view_en) begin
      color = heat_r;
    end else begin
      color = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    clr_nxt   = clr_r;
    alive_nxt = alive_r;
    cnt_nxt   = cnt_r;
    heat_nxt  = heat_r;
    q_pop     = 1'b0;
    load_item = 1'b0;
    out_load  = 1'b0;
    bw_en0    = 1'b0;
    bw_en1    = 1'b0;
    bw_addr   = here_addr;
    bw_data   = next_alive;
    hw_en     = 1'b0;
    hw_addr   = here_addr;
    hw_data   = heat_next(heat_r);
    unique case (state_r)
      S_CLEAR: begin
        hw_en   = 1'b1;
        hw_addr = clr_r;
        hw_data = '0;
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (e_kind)
            FUNC_SEED: begin
              bw_addr = e_bh + ADDR_W'(e_c);
              bw_data = e_seed;
              bw_en0  = !sel_r;
              bw_en1  = sel_r;
              hw_en   = 1'b1;
              hw_addr = e_bh + ADDR_W'(e_c);
              hw_data = '0;
            end
            FUNC_EVOLVE: begin
              load_item = 1'b1;
              state_nxt = S_RD0;
            end
            FUNC_SWAP: begin
              sel_nxt = !sel_r;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD0: begin
        state_nxt = S_RD1;
      end
      S_RD1: begin
        alive_nxt = rd_a;
        cnt_nxt   = COUNT_W'(rd_b);
        heat_nxt  = heat_rd;
        state_nxt = S_RD2;
      end
      S_RD2, S_RD3, S_RD4: begin
        cnt_nxt   = cnt_r + COUNT_W'(rd_a) + COUNT_W'(rd_b);
        state_nxt = state_r + 4'd1;
      end
      S_SUM: begin
        cnt_nxt   = cnt_r + COUNT_W'(rd_a);
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          bw_en0    = sel_r;
          bw_en1    = !sel_r;
          hw_en     = next_alive;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sel_r       <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    alive_r <= alive_nxt;
    cnt_r   <= cnt_nxt;
    heat_r  <= heat_nxt;
    if (load_item) begin
      c_r  <= e_c;
      cl_r <= e_cl;
      cr_r <= e_cr;
      r_r  <= e_r;
      bu_r <= e_bu;
      bh_r <= e_bh;
      bd_r <= e_bd;
    end
    if (out_load) begin
      out_col_r   <= COORD_IN_W'(c_r);
      out_row_r   <= COORD_IN_W'(r_r);
      out_alive_r <= next_alive;
      out_color_r <= color;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_color_r, out_alive_r, out_row_r, out_col_r};

  llae_ram #(.WIDTH(1), .DEPTH(CELLS)) u_bank_zero (
    .clk       (clk),
    .wr_en     (bw_en0),
    .wr_addr   (bw_addr),
    .wr_data   (bw_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (b0_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (b0_b)
  );

  llae_ram #(.WIDTH(1), .DEPTH(CELLS)) u_bank_one (
    .clk       (clk),
    .wr_en     (bw_en1),
    .wr_addr   (bw_addr),
    .wr_data   (bw_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (b1_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (b1_b)
  );

  llae_ram #(.WIDTH(HEAT_W), .DEPTH(CELLS)) u_heat (
    .clk       (clk),
    .wr_en     (hw_en),
    .wr_addr   (hw_addr),
    .wr_data   (hw_data),
    .rd_addr_a (here_addr),
    .rd_data_a (heat_rd),
    .rd_addr_b (here_addr),
    .rd_data_b ()
  );

endmodule
`default_nettype wire

// File: hdl/llae_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module llae_checker
  import llae_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output word present right after reset");

  a_clear_block: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_tready ##1 !in_tready)
    else $error("input accepted during heat clearing pass");

endmodule

bind life_like_automaton_engine_top llae_checker u_llae_checker (.*);
`default_nettype wire
